/* rtl/core/rpv_pkg.sv */
// ----------------------------------------------------------------------------
// rpv_pkg
// Shared types, byte codes and the reserved device stem check.
// ----------------------------------------------------------------------------
package rpv_pkg;

  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TILDE     = 8'h7e;
  localparam logic [7:0] CH_BACKSLASH = 8'h5c;
  localparam logic [7:0] CH_COLON     = 8'h3a;
  localparam logic [7:0] CH_SLASH     = 8'h2f;
  localparam logic [7:0] CH_DOT       = 8'h2e;
  localparam logic [7:0] CH_UPPER_A   = 8'h41;
  localparam logic [7:0] CH_UPPER_Z   = 8'h5a;
  localparam logic [7:0] CH_CASE_GAP  = 8'h20;
  localparam logic [7:0] CH_DIGIT_1   = 8'h31;
  localparam logic [7:0] CH_DIGIT_9   = 8'h39;

  localparam logic [23:0] STEM_CON = 24'h6e6f63;
  localparam logic [23:0] STEM_PRN = 24'h6e7270;
  localparam logic [23:0] STEM_AUX = 24'h787561;
  localparam logic [23:0] STEM_NUL = 24'h6c756e;
  localparam logic [23:0] STEM_COM = 24'h6d6f63;
  localparam logic [23:0] STEM_LPT = 24'h74706c;

  localparam logic [2:0] SEG_SAT  = 3'd5;
  localparam logic [2:0] STEM_MAX = 3'd4;

  typedef struct packed {
    logic [7:0] lower;
    logic       slash;
    logic       dot;
    logic       space;
    logic       bad;
    logic       present;
    logic       last;
  } item_t;

  function automatic logic stem_reserved(input logic [31:0] chars, input logic [2:0] len);
    logic [23:0] head;
    logic [7:0]  digit;
    logic        res;
    head  = chars[23:0];
    digit = chars[31:24];
    res   = 1'b0;
    if (len == 3'd3) begin
      res = (head == STEM_CON) || (head == STEM_PRN) ||
            (head == STEM_AUX) || (head == STEM_NUL);
    end else if (len == 3'd4) begin
      res = ((head == STEM_COM) || (head == STEM_LPT)) &&
            (digit >= CH_DIGIT_1) && (digit <= CH_DIGIT_9);
    end
    return res;
  endfunction

endpackage

/* rtl/core/rpv_fifo.sv */
// ----------------------------------------------------------------------------
// rpv_fifo
// Small register-based queue with simultaneous push and pop.
// ----------------------------------------------------------------------------
module rpv_fifo #(
  parameter int WIDTH = 1,
  parameter int AW    = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int DEPTH = 1 << AW;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]      count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == DEPTH[AW:0]);
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

/* rtl/core/rpv_front.sv */
// ----------------------------------------------------------------------------
// rpv_front
// Input stage: accept items, classify each byte, register it for the queue.
// ----------------------------------------------------------------------------
module rpv_front import rpv_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  logic [7:0] in_path_byte,
  input  logic       in_byte_present,
  input  logic       in_last_byte,
  output logic       in_full,
  output logic       q_push,
  output item_t      q_item,
  input  logic       q_full
);

  logic  valid_r, valid_nxt;
  item_t item_r;
  item_t item_cls;
  logic  accept;

  always_comb begin
    item_cls.lower   = ((in_path_byte >= CH_UPPER_A) && (in_path_byte <= CH_UPPER_Z)) ?
                       in_path_byte + CH_CASE_GAP : in_path_byte;
    item_cls.slash   = (in_path_byte == CH_SLASH);
    item_cls.dot     = (in_path_byte == CH_DOT);
    item_cls.space   = (in_path_byte == CH_SPACE);
    item_cls.bad     = (in_path_byte == CH_BACKSLASH) || (in_path_byte == CH_COLON) ||
                       (in_path_byte < CH_SPACE) || (in_path_byte > CH_TILDE);
    item_cls.present = in_byte_present;
    item_cls.last    = in_last_byte;
  end

  assign in_full = valid_r && q_full;
  assign accept  = in_push && !in_full;
  assign q_push  = valid_r;
  assign q_item  = item_r;

  // drop idle items that carry neither a byte nor the end mark
  always_comb begin
    valid_nxt = valid_r && q_full;
    if (accept && (in_byte_present || in_last_byte)) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_cls;
    end
  end

endmodule

/* rtl/core/rpv_back.sv */
// ----------------------------------------------------------------------------
// rpv_back
// Path state: length, segment and stem tracking; issues the verdict.
// ----------------------------------------------------------------------------
module rpv_back import rpv_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [15:0] max_path_bytes,
  input  item_t       q_item,
  input  logic        q_empty,
  output logic        q_pop,
  output logic        res_push,
  output logic        res_valid,
  input  logic        res_full
);

  logic [15:0] bytes_seen_r, bytes_seen_nxt;
  logic        failed_r, failed_nxt;
  logic [2:0]  seg_len_r, seg_len_nxt;
  logic [31:0] stem_r, stem_nxt;
  logic [2:0]  stem_len_r, stem_len_nxt;
  logic        stem_closed_r, stem_closed_nxt;
  logic        prev_ds_r, prev_ds_nxt;

  logic [15:0] bytes_a;
  logic        fail_a;
  logic [2:0]  seg_len_a;
  logic [31:0] stem_a;
  logic [2:0]  stem_len_a;
  logic        stem_closed_a;
  logic        prev_ds_a;
  logic        fail_b;

  assign q_pop     = !q_empty && (!q_item.last || !res_full);
  assign res_push  = q_pop && q_item.last;
  assign res_valid = !fail_b;

  always_comb begin
    bytes_a       = bytes_seen_r;
    fail_a        = failed_r;
    seg_len_a     = seg_len_r;
    stem_a        = stem_r;
    stem_len_a    = stem_len_r;
    stem_closed_a = stem_closed_r;
    prev_ds_a     = prev_ds_r;
    if (q_item.present) begin
      if (bytes_seen_r >= max_path_bytes) begin
        fail_a = 1'b1;
      end
      if (bytes_seen_r != 16'hffff) begin
        bytes_a = bytes_seen_r + 16'd1;
      end
      if (q_item.bad) begin
        fail_a = 1'b1;
      end
      if (q_item.slash) begin
        if ((seg_len_r == '0) || prev_ds_r || stem_reserved(stem_r, stem_len_r)) begin
          fail_a = 1'b1;
        end
        seg_len_a     = '0;
        stem_a        = '0;
        stem_len_a    = '0;
        stem_closed_a = 1'b0;
      end else begin
        if (seg_len_r < SEG_SAT) begin
          seg_len_a = seg_len_r + 3'd1;
        end
        if (!stem_closed_r) begin
          if (q_item.dot) begin
            stem_closed_a = 1'b1;
          end else if (stem_len_r < SEG_SAT) begin
            if (stem_len_r < STEM_MAX) begin
              stem_a[{stem_len_r[1:0], 3'b000} +: 8] = q_item.lower;
            end
            stem_len_a = stem_len_r + 3'd1;
          end
        end
      end
      prev_ds_a = q_item.dot || q_item.space;
    end
    // close the final segment
    fail_b = fail_a;
    if ((seg_len_a == '0) || prev_ds_a || stem_reserved(stem_a, stem_len_a)) begin
      fail_b = 1'b1;
    end
  end

  always_comb begin
    bytes_seen_nxt  = bytes_seen_r;
    failed_nxt      = failed_r;
    seg_len_nxt     = seg_len_r;
    stem_nxt        = stem_r;
    stem_len_nxt    = stem_len_r;
    stem_closed_nxt = stem_closed_r;
    prev_ds_nxt     = prev_ds_r;
    if (q_pop) begin
      if (q_item.last) begin
        bytes_seen_nxt  = '0;
        failed_nxt      = 1'b0;
        seg_len_nxt     = '0;
        stem_nxt        = '0;
        stem_len_nxt    = '0;
        stem_closed_nxt = 1'b0;
        prev_ds_nxt     = 1'b0;
      end else begin
        bytes_seen_nxt  = bytes_a;
        failed_nxt      = fail_a;
        seg_len_nxt     = seg_len_a;
        stem_nxt        = stem_a;
        stem_len_nxt    = stem_len_a;
        stem_closed_nxt = stem_closed_a;
        prev_ds_nxt     = prev_ds_a;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_seen_r  <= '0;
      failed_r      <= 1'b0;
      seg_len_r     <= '0;
      stem_r        <= '0;
      stem_len_r    <= '0;
      stem_closed_r <= 1'b0;
      prev_ds_r     <= 1'b0;
    end else begin
      bytes_seen_r  <= bytes_seen_nxt;
      failed_r      <= failed_nxt;
      seg_len_r     <= seg_len_nxt;
      stem_r        <= stem_nxt;
      stem_len_r    <= stem_len_nxt;
      stem_closed_r <= stem_closed_nxt;
      prev_ds_r     <= prev_ds_nxt;
    end
  end

endmodule

/* rtl/core/relative_path_validator_unit.sv */
// ----------------------------------------------------------------------------
// relative_path_validator_unit
// Streams a relative path byte by byte and returns one valid/invalid verdict.
//
//   channel | ports                                    | moves
//   --------+------------------------------------------+----------------------
//   input   | in_push/in_full, in_path_byte, in_byte_* | one byte or end mark
//   result  | out_pop/out_empty, out_path_valid        | one verdict per path
//   config  | cfg_psel/penable/pwrite/paddr/pwdata     | max_path_bytes @ 0x0
//
// One item per cycle sustained while neither stall below holds the flow; a verdict
// follows its final item through the classify register and both queues.
// Reset clears the queues and path state; max_path_bytes returns to 1024.
// The input stalls only when the classify register and item queue are full;
// the back stage stalls on a final item only while the result queue is full.
// ----------------------------------------------------------------------------
module relative_path_validator_unit import rpv_pkg::*; #(
  parameter int ITEM_Q_AW = 2,
  parameter int RES_Q_AW  = 1
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic [7:0]  in_path_byte,
  input  logic        in_byte_present,
  input  logic        in_last_byte,
  output logic        in_full,
  input  logic        out_pop,
  output logic        out_path_valid,
  output logic        out_empty,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam logic [15:0] MAX_PATH_RESET = 16'd1024;
  localparam logic [1:0]  ADDR_MAX_PATH  = 2'd0;

  logic [15:0] max_path_r;
  logic        cfg_wr;
  logic        q_push, q_full, q_pop, q_empty;
  item_t       q_witem, q_ritem;
  logic        res_push, res_valid, res_full;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr == ADDR_MAX_PATH) ? {16'd0, max_path_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_path_r <= MAX_PATH_RESET;
    end else if (cfg_wr && (cfg_paddr == ADDR_MAX_PATH)) begin
      max_path_r <= cfg_pwdata[15:0];
    end
  end

  rpv_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_path_byte    (in_path_byte),
    .in_byte_present (in_byte_present),
    .in_last_byte    (in_last_byte),
    .in_full         (in_full),
    .q_push          (q_push),
    .q_item          (q_witem),
    .q_full          (q_full)
  );

  rpv_fifo #(
    .WIDTH ($bits(item_t)),
    .AW    (ITEM_Q_AW)
  ) u_item_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_witem),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_ritem),
    .empty (q_empty)
  );

  rpv_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .max_path_bytes (max_path_r),
    .q_item         (q_ritem),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .res_push       (res_push),
    .res_valid      (res_valid),
    .res_full       (res_full)
  );

  rpv_fifo #(
    .WIDTH (1),
    .AW    (RES_Q_AW)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_valid),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (out_path_valid),
    .empty (out_empty)
  );

  a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("verdict pushed into full result queue");

  a_empty_path_fails: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && !q_ritem.present && (u_back.seg_len_r == '0)) |-> !res_valid)
    else $error("path ending in empty segment judged valid");

  a_front_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && q_full) |=> q_push && $stable(q_witem))
    else $error("classified item lost while item queue full");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

endmodule
